// ----- rtl/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// lrupr_pkg: shared types and constants
// Defaults, fixed field widths, sequencer states and cell update operations.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_IN_W = 16;
    localparam int CFG_W     = 4;
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        OP_TOUCH,
        OP_FILL,
        OP_REPLACE
    } t_op;

    typedef struct packed {
        logic en;
        t_op  op;
    } t_cmd;

endpackage

// ----- rtl/lrupr_cell.sv -----
// ----------------------------------------------------------------------------
// lrupr_cell: one page frame of the chain
// Holds page, valid flag and age; passes the first-match and oldest-frame
// search results to its neighbor and applies the broadcast update.
// ----------------------------------------------------------------------------
module lrupr_cell #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int CELL_ID   = 0,
    localparam int IW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_in_range,
    input  logic                 i_hfound,
    input  logic [IW-1:0]        i_hidx,
    input  logic [IW-1:0]        i_hage,
    input  logic                 i_ofound,
    input  logic [IW-1:0]        i_oidx,
    input  logic [IW-1:0]        i_oage,
    output logic                 o_hfound,
    output logic [IW-1:0]        o_hidx,
    output logic [IW-1:0]        o_hage,
    output logic                 o_ofound,
    output logic [IW-1:0]        o_oidx,
    output logic [IW-1:0]        o_oage,
    input  lrupr_pkg::t_cmd      i_cmd,
    input  logic [IW-1:0]        i_slot,
    input  logic [IW-1:0]        i_old_age
);

    localparam logic [IW-1:0] MY_ID = IW'(CELL_ID);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [IW-1:0]        r_rank;
    logic                 match;
    logic                 cand;
    logic                 sel;

    assign match = r_valid && i_in_range && (r_page == i_page);
    assign cand  = r_valid && i_in_range;
    assign sel   = (i_slot == MY_ID);

    always_comb begin
        o_hfound = i_hfound | match;
        o_hidx   = i_hidx;
        o_hage   = i_hage;
        if (match && !i_hfound) begin
            o_hidx = MY_ID;
            o_hage = r_rank;
        end
        o_ofound = i_ofound | cand;
        o_oidx   = i_oidx;
        o_oage   = i_oage;
        if (cand && (!i_ofound || r_rank > i_oage)) begin
            o_oidx = MY_ID;
            o_oage = r_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_cmd.en) begin
            case (i_cmd.op)
                lrupr_pkg::OP_FILL: begin
                    if (sel) begin
                        r_valid <= 1'b1;
                        r_rank  <= '0;
                    end else if (r_valid) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                lrupr_pkg::OP_TOUCH, lrupr_pkg::OP_REPLACE: begin
                    if (sel) begin
                        r_valid <= 1'b1;
                        r_rank  <= '0;
                    end else if (r_valid && r_rank < i_old_age) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                default: begin
                    r_rank <= r_rank;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en && sel && i_cmd.op != lrupr_pkg::OP_TOUCH) begin
            r_page <= i_page;
        end
    end

endmodule

// ----- rtl/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement: fully associative LRU page frame store
// Looks up each page reference in a chain of frame cells and reports hit,
// frame and running fault count.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_page_number. Output channel:
// o_out_valid / i_out_stall with o_hit, o_frame_slot and o_fault_count.
// A transaction moves at a clock edge with valid high and stall low.
// Each reference passes through a search cycle, in which the page is
// compared in every cell and the first match and the oldest frame ripple
// along the cell chain, and an update cycle, in which the chosen frame is
// written and the ages shift. The result is registered at the end of the
// update cycle, and a new reference is taken in the update cycle. If the
// receiver stalls with a result still held, the update waits and
// o_in_stall stays high until the output register frees.
// i_cfg_we writes the number of managed frames (0 acts as 1, values above
// the frame count act as the frame count); write it only while idle.
// Synchronous reset empties all frames, clears ages, fill pointer and fault
// count, and sets the managed range to all frames.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lrupr_pkg::PAGE_IN_W-1:0] i_page_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]  o_frame_slot,
    output logic [lrupr_pkg::COUNT_W-1:0] o_fault_count
);

    localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW  = $clog2(FRAMES + 1);
    localparam int RW  = (CW > lrupr_pkg::CFG_W) ? CW : lrupr_pkg::CFG_W;
    localparam logic [lrupr_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    lrupr_pkg::t_state r_state, n_state;

    logic [RW-1:0]                  r_cfg;
    logic [PAGE_BITS-1:0]           r_page, n_page;
    logic [CW-1:0]                  r_fill, n_fill;
    logic [lrupr_pkg::COUNT_W-1:0]  r_faults, n_faults;
    logic                           r_hit, n_hit;
    logic [IW-1:0]                  r_slot, n_slot;
    logic [IW-1:0]                  r_old_age, n_old_age;
    lrupr_pkg::t_op                 r_op, n_op;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_hit, n_out_hit;
    logic [lrupr_pkg::SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [lrupr_pkg::COUNT_W-1:0]  r_out_count, n_out_count;

    logic [CW-1:0]    range_n;
    logic             out_free;
    logic             in_ready;
    logic             accept;
    logic             commit;
    lrupr_pkg::t_cmd  cmd;

    logic [FRAMES:0]  c_hfound;
    logic [FRAMES:0]  c_ofound;
    logic [IW-1:0]    c_hidx [FRAMES+1];
    logic [IW-1:0]    c_hage [FRAMES+1];
    logic [IW-1:0]    c_oidx [FRAMES+1];
    logic [IW-1:0]    c_oage [FRAMES+1];

    always_comb begin
        if (r_cfg == '0) begin
            range_n = CW'(1);
        end else if (32'(r_cfg) > 32'(FRAMES)) begin
            range_n = CW'(FRAMES);
        end else begin
            range_n = CW'(r_cfg);
        end
    end

    assign c_hfound[0] = 1'b0;
    assign c_ofound[0] = 1'b0;
    assign c_hidx[0]   = '0;
    assign c_hage[0]   = '0;
    assign c_oidx[0]   = '0;
    assign c_oage[0]   = '0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lrupr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .CELL_ID   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_page     (r_page),
            .i_in_range (32'(g) < 32'(range_n)),
            .i_hfound   (c_hfound[g]),
            .i_hidx     (c_hidx[g]),
            .i_hage     (c_hage[g]),
            .i_ofound   (c_ofound[g]),
            .i_oidx     (c_oidx[g]),
            .i_oage     (c_oage[g]),
            .o_hfound   (c_hfound[g+1]),
            .o_hidx     (c_hidx[g+1]),
            .o_hage     (c_hage[g+1]),
            .o_ofound   (c_ofound[g+1]),
            .o_oidx     (c_oidx[g+1]),
            .o_oage     (c_oage[g+1]),
            .i_cmd      (cmd),
            .i_slot     (r_slot),
            .i_old_age  (r_old_age)
        );
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == lrupr_pkg::ST_UPDATE) && out_free;

    always_comb begin
        case (r_state)
            lrupr_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lrupr_pkg::ST_LOOK;
                end else begin
                    n_state = lrupr_pkg::ST_IDLE;
                end
            end
            lrupr_pkg::ST_LOOK: begin
                n_state = lrupr_pkg::ST_UPDATE;
            end
            lrupr_pkg::ST_UPDATE: begin
                if (accept) begin
                    n_state = lrupr_pkg::ST_LOOK;
                end else if (commit) begin
                    n_state = lrupr_pkg::ST_IDLE;
                end else begin
                    n_state = lrupr_pkg::ST_UPDATE;
                end
            end
            default: begin
                n_state = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            lrupr_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.en   = 1'b0;
            end
            lrupr_pkg::ST_LOOK: begin
                in_ready = 1'b0;
                cmd.en   = 1'b0;
            end
            lrupr_pkg::ST_UPDATE: begin
                in_ready = out_free;
                cmd.en   = out_free;
            end
            default: begin
                in_ready = 1'b0;
                cmd.en   = 1'b0;
            end
        endcase
        cmd.op = r_op;
    end

    assign accept     = in_ready && i_in_valid;
    assign o_in_stall = !in_ready;

    always_comb begin
        n_page      = r_page;
        n_fill      = r_fill;
        n_faults    = r_faults;
        n_hit       = r_hit;
        n_slot      = r_slot;
        n_old_age   = r_old_age;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_slot  = r_out_slot;
        n_out_count = r_out_count;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_page = PAGE_BITS'(i_page_number);
        end

        if (r_state == lrupr_pkg::ST_LOOK) begin
            n_hit = c_hfound[FRAMES];
            if (c_hfound[FRAMES]) begin
                n_op      = lrupr_pkg::OP_TOUCH;
                n_slot    = c_hidx[FRAMES];
                n_old_age = c_hage[FRAMES];
            end else if (r_fill < range_n) begin
                n_op      = lrupr_pkg::OP_FILL;
                n_slot    = IW'(r_fill);
                n_old_age = '0;
            end else begin
                n_op      = lrupr_pkg::OP_REPLACE;
                n_slot    = c_oidx[FRAMES];
                n_old_age = c_oage[FRAMES];
            end
        end

        if (commit) begin
            if (r_op == lrupr_pkg::OP_FILL) begin
                n_fill = r_fill + 1'b1;
            end
            if (!r_hit && r_faults != COUNT_MAX) begin
                n_faults = r_faults + 1'b1;
            end
            n_out_valid = 1'b1;
            n_out_hit   = r_hit;
            n_out_slot  = lrupr_pkg::SLOT_W'(r_slot);
            n_out_count = n_faults;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrupr_pkg::ST_IDLE;
            r_cfg       <= RW'(FRAMES);
            r_fill      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
            r_op        <= lrupr_pkg::OP_TOUCH;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_faults    <= n_faults;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            if (i_cfg_we) begin
                r_cfg <= RW'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page      <= n_page;
        r_hit       <= n_hit;
        r_slot      <= n_slot;
        r_old_age   <= n_old_age;
        r_out_hit   <= n_out_hit;
        r_out_slot  <= n_out_slot;
        r_out_count <= n_out_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_frame_slot  = r_out_slot;
    assign o_fault_count = r_out_count;

endmodule

// ----- tb/tb_lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// tb_lru_page_replacement: self-checking bench for the LRU page frame store
// Runs a directed table of page references and range writes, then random
// reference streams drawn from small working sets under several idle and
// stall mixes and a long receiver hold-off.
// Every result is compared field by field against an in-bench LRU predictor,
// or against typed values for the first directed rows.
module tb_lru_page_replacement;

    localparam int FRAMES       = lrupr_pkg::FRAMES_DEF;
    localparam int PAGE_W       = lrupr_pkg::PAGE_IN_W;
    localparam int CFG_W        = lrupr_pkg::CFG_W;
    localparam int SLOT_W       = lrupr_pkg::SLOT_W;
    localparam int COUNT_W      = lrupr_pkg::COUNT_W;
    localparam int LIMIT_CYCLES = 100_000;
    localparam int LONG_HOLD    = 80;
    localparam int PRINT_MAX    = 50;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] faults;
    } t_want;

    typedef enum logic [0:0] {
        ROW_REF,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] value;
        logic        typed;
        t_want       want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [PAGE_W-1:0]  i_page_number = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_hit;
    logic [SLOT_W-1:0]  o_frame_slot;
    logic [COUNT_W-1:0] o_fault_count;

    // predictor state
    logic [PAGE_W-1:0]  frame_page [FRAMES];
    logic               frame_used [FRAMES];
    logic [2:0]         frame_age  [FRAMES];
    logic [3:0]         frames_filled;
    logic [COUNT_W-1:0] fault_total;
    logic [CFG_W-1:0]   managed_cfg;

    t_want pending_results [$];

    int errors = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_ticket = 0;
    int hold_seen = 0;
    int hold_left = 0;

    t_plan_row plan [24] = '{
        '{ROW_REF, 16'h0000, 1'b1, '{1'b0, 3'd0, 16'd1}},
        '{ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 16'd2}},
        '{ROW_REF, 16'h0000, 1'b1, '{1'b1, 3'd0, 16'd2}},
        '{ROW_CFG, 16'd2,    1'b0, '0},
        '{ROW_REF, 16'h8001, 1'b0, '0},
        '{ROW_REF, 16'h0000, 1'b0, '0},
        '{ROW_CFG, 16'd15,   1'b0, '0},
        '{ROW_REF, 16'h7FFE, 1'b0, '0},
        '{ROW_REF, 16'h5555, 1'b0, '0},
        '{ROW_REF, 16'hAAAA, 1'b0, '0},
        '{ROW_REF, 16'h1234, 1'b0, '0},
        '{ROW_REF, 16'hFEDC, 1'b0, '0},
        '{ROW_REF, 16'h0F0F, 1'b0, '0},
        '{ROW_REF, 16'h4321, 1'b0, '0},
        '{ROW_CFG, 16'd0,    1'b0, '0},
        '{ROW_REF, 16'hFFFF, 1'b0, '0},
        '{ROW_REF, 16'h0001, 1'b0, '0},
        '{ROW_CFG, 16'd3,    1'b0, '0},
        '{ROW_REF, 16'h5555, 1'b0, '0},
        '{ROW_REF, 16'h8001, 1'b0, '0},
        '{ROW_CFG, 16'd8,    1'b0, '0},
        '{ROW_REF, 16'h5555, 1'b0, '0},
        '{ROW_REF, 16'h0000, 1'b0, '0},
        '{ROW_REF, 16'hFFFF, 1'b0, '0}
    };

    lru_page_replacement i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_page_number (i_page_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_frame_slot  (o_frame_slot),
        .o_fault_count (o_fault_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic void age_to_front(input int f, input int old_age);
        for (int i = 0; i < FRAMES; i++) begin
            if (frame_used[i] && i != f && int'(frame_age[i]) < old_age) begin
                frame_age[i] = frame_age[i] + 3'd1;
            end
        end
        frame_age[f] = 3'd0;
    endfunction

    task automatic lru_lookup(input logic [PAGE_W-1:0] page, output t_want res);
        int  lim;
        int  slot;
        int  oldest;
        bit  found;
        bit  is_hit;
        lim = (managed_cfg == 0) ? 1 : ((managed_cfg > FRAMES) ? FRAMES : int'(managed_cfg));
        slot = 0;
        is_hit = 1'b0;
        for (int i = 0; i < lim; i++) begin
            if (!is_hit && frame_used[i] && frame_page[i] == page) begin
                is_hit = 1'b1;
                slot = i;
            end
        end
        if (is_hit) begin
            age_to_front(slot, int'(frame_age[slot]));
        end else if (int'(frames_filled) < lim) begin
            slot = int'(frames_filled);
            frames_filled = frames_filled + 4'd1;
            for (int i = 0; i < FRAMES; i++) begin
                if (frame_used[i]) begin
                    frame_age[i] = frame_age[i] + 3'd1;
                end
            end
            frame_page[slot] = page;
            frame_used[slot] = 1'b1;
            frame_age[slot] = 3'd0;
        end else begin
            found = 1'b0;
            oldest = 0;
            for (int i = 0; i < lim; i++) begin
                if (frame_used[i] && (!found || int'(frame_age[i]) > oldest)) begin
                    found = 1'b1;
                    oldest = int'(frame_age[i]);
                    slot = i;
                end
            end
            frame_page[slot] = page;
            frame_used[slot] = 1'b1;
            age_to_front(slot, oldest);
        end
        if (!is_hit && fault_total != {COUNT_W{1'b1}}) begin
            fault_total = fault_total + 1'b1;
        end
        res.hit = is_hit;
        res.slot = slot[SLOT_W-1:0];
        res.faults = fault_total;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_MAX) begin
            $display("mismatch at result %0d: %0s got %0h want %0h",
                     results_seen, what, got, want);
        end
        errors++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_page(input logic [PAGE_W-1:0] page, input bit use_typed,
                             input t_want typed);
        t_want predicted;
        int    gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (o_in_stall);
        lru_lookup(page, predicted);
        pending_results.push_back(use_typed ? typed : predicted);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        managed_cfg = value;
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
                             input logic [CFG_W-1:0] frames, input bit long_hold);
        logic [PAGE_W-1:0] pool [12];
        int                pool_n;
        logic [PAGE_W-1:0] page;
        write_frames(frames);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        pool_n = $urandom_range(12, 2);
        for (int i = 0; i < 12; i++) begin
            pool[i] = PAGE_W'($urandom);
        end
        if (long_hold) begin
            hold_ticket++;
        end
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 85) begin
                page = pool[$urandom_range(pool_n - 1)];
            end else begin
                page = PAGE_W'($urandom);
            end
            send_page(page, 1'b0, '0);
        end
        i_in_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_want want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_lru_page_replacement: errors");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("transaction with nothing pending, fault_count",
                                int'(o_fault_count), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    report_mismatch("hit", int'(o_hit), int'(want.hit));
                end
                if (o_frame_slot !== want.slot) begin
                    report_mismatch("frame_slot", int'(o_frame_slot), int'(want.slot));
                end
                if (o_fault_count !== want.faults) begin
                    report_mismatch("fault_count", int'(o_fault_count),
                                    int'(want.faults));
                end
            end
            results_seen++;
        end
    end

    initial begin
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_used[i] = 1'b0;
            frame_age[i] = 3'd0;
        end
        frames_filled = '0;
        fault_total = '0;
        managed_cfg = CFG_W'(FRAMES);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                write_frames(plan[r].value[CFG_W-1:0]);
            end else begin
                send_page(plan[r].value, plan[r].typed, plan[r].want);
            end
        end
        i_in_valid <= 1'b0;

        run_phase(125, 0, 0, 4'd8, 1'b0);
        run_phase(125, 63, 0, 4'd4, 1'b0);
        run_phase(125, 0, 63, 4'd1, 1'b0);
        run_phase(125, 38, 38, 4'd15, 1'b0);
        run_phase(125, 0, 0, 4'd6, 1'b1);
        run_phase(125, 38, 38, CFG_W'($urandom_range(15)), 1'b0);
        run_phase(30, 0, 0, 4'd0, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_lru_page_replacement: clean");
        end else begin
            $display("tb_lru_page_replacement: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lrupr_pkg.sv
rtl/lrupr_cell.sv
rtl/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
